### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, widths and codes for the sorted priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int PRI_W   = 16;
  localparam int PAY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int ECOUNT_W = 5;

  // request kinds
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_DEQUEUE = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic deq;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: one insert or dequeue per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [PRI_W-1:0] new_priority;
  logic [PAY_W-1:0] new_payload;

  modport source (output valid, kind, new_priority, new_payload, input ready);
  modport sink   (input valid, kind, new_priority, new_payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: one result per request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [PRI_W-1:0]    taken_priority;
  logic [PAY_W-1:0]    taken_payload;
  logic                head_valid;
  logic [PRI_W-1:0]    head_priority;
  logic [PAY_W-1:0]    head_payload;
  logic [ECOUNT_W-1:0] entry_count;
  logic                is_empty;

  modport source (
    output valid, status, taken_priority, taken_payload, head_valid,
           head_priority, head_payload, entry_count, is_empty,
    input  ready
  );
  modport sink (
    input  valid, status, taken_priority, taken_payload, head_valid,
           head_priority, head_payload, entry_count, is_empty,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                 clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  input  wire                 left_lt,
  input  spq_pkg::entry_t     right_entry,
  input  wire                 occupied,
  output spq_pkg::entry_t     entry,
  output spq_pkg::entry_t     entry_next,
  output logic                lt
);
  import spq_pkg::*;

  // entry stays ahead of the new one when strictly lower
  assign lt = occupied && (entry.pri < new_entry.pri);

  // insert: hold, take new at the boundary, else shift right; dequeue: shift left
  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (!lt) begin
        entry_next = left_lt ? new_entry : left_entry;
      end
    end else if (ctrl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted priority queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Holds up to DEPTH (priority, payload) entries in ascending priority order,
// cell 0 being the front. Each request transaction is an insert or a dequeue
// and produces exactly one response transaction. Every cell compares its
// entry with the new priority in parallel and then holds, takes the new entry
// or shifts by one place, so a new request can be taken every cycle; the only
// limit is the response register, which frees when its transaction is taken.
// Among equal priorities the newest entry is served first. An insert into a
// full queue is refused with a full status, and a dequeue from an empty queue
// returns an empty status.
`default_nettype none

module sorted_priority_queue_core (
  input wire clk,
  input wire rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cell_entry [DEPTH];
  entry_t           cell_next  [DEPTH];
  logic             cell_lt    [DEPTH];
  status_t          status_next;
  entry_t           taken_next;
  logic [31:0]      count_wide;

  // request handshake
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  assign new_entry.pri = req.new_priority;
  assign new_entry.pay = req.new_payload;

  assign ctrl.ins = accept && (req.kind == KIND_INSERT) && !full;
  assign ctrl.deq = accept && (req.kind == KIND_DEQUEUE) && !empty;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_l;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_l = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .occupied    (count > CNT_W'(i)),
      .entry       (cell_entry[i]),
      .entry_next  (cell_next[i]),
      .lt          (cell_lt[i])
    );
  end

  // occupancy count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  // result status and dequeued entry
  always_comb begin
    status_next = STATUS_OK;
    taken_next  = '0;
    if (req.kind == KIND_INSERT) begin
      if (full) begin
        status_next = STATUS_FULL;
      end
    end else if (empty) begin
      status_next = STATUS_EMPTY;
    end else begin
      taken_next = cell_entry[0];
    end
  end

  assign count_wide = 32'(count_next);

  // count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.status         <= status_next;
      rsp.taken_priority <= taken_next.pri;
      rsp.taken_payload  <= taken_next.pay;
      rsp.head_valid     <= (count_next != '0);
      rsp.head_priority  <= (count_next != '0) ? cell_next[0].pri : '0;
      rsp.head_payload   <= (count_next != '0) ? cell_next[0].pay : '0;
      rsp.entry_count    <= count_wide[ECOUNT_W-1:0];
      rsp.is_empty       <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire

### dv/sorted_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb
// Self-checking bench for the sorted priority queue core.
// ----------------------------------------------------------------------------
// Drives insert and dequeue requests through the request channel. A local
// sorted-array model predicts every response: status, the taken entry, the
// front entry, the count and the empty flag. Each response is compared field
// by field. The run covers directed edge cases, fill and overflow to the full
// state, drain past empty, long random mixes, a long response hold-off that
// backs up the input, and gap-free bursts.
`default_nettype none

module sorted_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_GAP = 5;

  // expected contents of one response transaction
  typedef struct packed {
    status_t          status;
    logic [PRI_W-1:0] taken_pri;
    logic [PAY_W-1:0] taken_pay;
    logic             head_valid;
    logic [PRI_W-1:0] head_pri;
    logic [PAY_W-1:0] head_pay;
    logic [4:0]       count;
    logic             empty;
  } outcome_t;

  logic clk;
  logic rst;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // queue model and expected responses
  entry_t      model_slots [DEPTH];
  int unsigned model_count;
  outcome_t    pending_outcomes [$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned checked_count;
  int unsigned insert_count;
  int unsigned dequeue_count;
  int unsigned full_refusals;
  int unsigned empty_dequeues;
  int unsigned peak_count;

  // idle control, no_gaps shared by both sides and rx_hold_cycles by the response side only
  bit          no_gaps;
  int unsigned rx_hold_cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // apply one operation to the model and return the response it gives
  function automatic outcome_t predict_queue_op(logic kind, logic [PRI_W-1:0] pri,
                                                logic [PAY_W-1:0] pay);
    outcome_t    res;
    int unsigned pos;
    res = '0;
    res.status = STATUS_OK;
    if (kind == KIND_INSERT) begin
      insert_count++;
      if (model_count >= DEPTH) begin
        res.status = STATUS_FULL;
        full_refusals++;
      end else begin
        // new entry goes ahead of all equal or greater priorities
        pos = 0;
        while (pos < model_count && model_slots[pos].pri < pri) pos++;
        for (int i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos].pri = pri;
        model_slots[pos].pay = pay;
        model_count++;
      end
    end else begin
      dequeue_count++;
      if (model_count == 0) begin
        res.status = STATUS_EMPTY;
        empty_dequeues++;
      end else begin
        res.taken_pri = model_slots[0].pri;
        res.taken_pay = model_slots[0].pay;
        for (int i = 1; i < model_count; i++) model_slots[i-1] = model_slots[i];
        model_count--;
      end
    end
    if (model_count > peak_count) peak_count = model_count;
    if (model_count > 0) begin
      res.head_valid = 1'b1;
      res.head_pri   = model_slots[0].pri;
      res.head_pay   = model_slots[0].pay;
    end
    res.count = model_count[4:0];
    res.empty = (model_count == 0);
    return res;
  endfunction

  // predict on every accepted request transaction
  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready)
      pending_outcomes = {pending_outcomes,
                          predict_queue_op(req_bus.kind, req_bus.new_priority,
                                           req_bus.new_payload)};
  end

  task automatic compare_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // check every accepted response transaction against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("response transaction with no request outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        checked_count++;
        compare_field("status", PAY_W'(want.status), PAY_W'(rsp_bus.status));
        compare_field("taken_priority", PAY_W'(want.taken_pri),
                      PAY_W'(rsp_bus.taken_priority));
        compare_field("taken_payload", want.taken_pay, rsp_bus.taken_payload);
        compare_field("head_valid", PAY_W'(want.head_valid), PAY_W'(rsp_bus.head_valid));
        compare_field("head_priority", PAY_W'(want.head_pri), PAY_W'(rsp_bus.head_priority));
        compare_field("head_payload", want.head_pay, rsp_bus.head_payload);
        compare_field("entry_count", PAY_W'(want.count), PAY_W'(rsp_bus.entry_count));
        compare_field("is_empty", PAY_W'(want.empty), PAY_W'(rsp_bus.is_empty));
      end
    end
  end

  // response side: random stalls, or a long hold-off when one is requested
  initial begin
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // offer one request and hold it until the transaction completes
  task automatic offer_request(logic kind, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.kind         <= kind;
    req_bus.new_priority <= pri;
    req_bus.new_payload  <= pay;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // lots of ties in a narrow band, plus the extremes and the full range
  function automatic logic [PRI_W-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return PRI_W'($urandom_range(0, 7));
    if (sel == 6) return $urandom_range(0, 1) ? '1 : '0;
    return PRI_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic pick_kind(int unsigned insert_pct);
    return ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DEQUEUE;
  endfunction

  task automatic send_random(int unsigned n, int unsigned insert_pct);
    repeat (n) offer_request(pick_kind(insert_pct), pick_priority(), $urandom());
  endtask

  // sender stops until every response has come back
  task automatic wait_for_drain();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // empty dequeue, field extremes and tie ordering
  task automatic test_directed();
    offer_request(KIND_DEQUEUE, '0, '0);
    offer_request(KIND_INSERT, 16'hffff, 32'hffff_ffff);
    offer_request(KIND_INSERT, 16'h0000, 32'h0000_0000);
    offer_request(KIND_INSERT, 16'h8000, 32'ha5a5_a5a5);
    offer_request(KIND_INSERT, 16'h8000, 32'h0000_0001);
    offer_request(KIND_INSERT, 16'h8000, 32'h0000_0002);
    offer_request(KIND_INSERT, 16'h8000, 32'h0000_0003);
    offer_request(KIND_INSERT, 16'h0000, 32'h5a5a_5a5a);
    repeat (8) offer_request(KIND_DEQUEUE, 16'hffff, 32'hffff_ffff);
    wait_for_drain();
  endtask

  // fill to full, push past it, then drain past empty
  task automatic test_fill_and_overflow(int unsigned rounds);
    repeat (rounds) begin
      repeat (DEPTH + 2) offer_request(KIND_INSERT, pick_priority(), $urandom());
      repeat (DEPTH + 2) offer_request(KIND_DEQUEUE, pick_priority(), $urandom());
    end
    wait_for_drain();
  endtask

  // random mix with the insert bias swinging so the count sweeps its range
  task automatic test_random_mix(int unsigned phases, int unsigned per_phase);
    int unsigned bias;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: bias = 75;
        1: bias = 50;
        2: bias = 25;
        default: bias = $urandom_range(10, 90);
      endcase
      send_random(per_phase, bias);
    end
    wait_for_drain();
  endtask

  // long response hold-off while requests keep coming
  task automatic test_backpressure();
    no_gaps = 1'b1;
    rx_hold_cycles = 80;
    send_random(40, 60);
    no_gaps = 1'b0;
    wait_for_drain();
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_burst(int unsigned n);
    no_gaps = 1'b1;
    send_random(n, 50);
    no_gaps = 1'b0;
    wait_for_drain();
  endtask

  initial begin
    rst = 1'b1;
    no_gaps = 1'b0;
    rx_hold_cycles = 0;
    model_count = 0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_INSERT;
    req_bus.new_priority = '0;
    req_bus.new_payload = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_overflow(3);
    test_random_mix(8, 90);
    test_backpressure();
    test_burst(200);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d responses: %0d inserts (%0d refused full), %0d dequeues",
             checked_count, insert_count, full_refusals, dequeue_count);
    $display("%0d dequeues on an empty queue, peak occupancy %0d of %0d",
             empty_dequeues, peak_count, DEPTH);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
